FILE: src/three_axis_proportional_rate_split_core_macros.svh
// Assertion macros shared by the checker of the three-axis rate split core.
`ifndef THREE_AXIS_PROPORTIONAL_RATE_SPLIT_CORE_MACROS_SVH
`define THREE_AXIS_PROPORTIONAL_RATE_SPLIT_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TAPRS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TAPRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/taprs_pkg.sv
// Types and constants of the three-axis proportional rate split core.
`default_nettype none

package taprs_pkg;

   localparam int NUM_PROFILES   = 4;
   localparam int PROFILE_BITS   = 2;
   localparam int SPEED_BITS     = 16;
   localparam int ACCEL_BITS     = 18;
   localparam int SPEED_OUT_BITS = 24;
   localparam int ACCEL_OUT_BITS = 26;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 18;

   typedef enum logic {
      OP_SYNC = 1'b0,
      OP_PUSH = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SPEED_0 = 3'd0,
      CSR_SPEED_1 = 3'd1,
      CSR_SPEED_2 = 3'd2,
      CSR_SPEED_3 = 3'd3,
      CSR_ACCEL_0 = 3'd4,
      CSR_ACCEL_1 = 3'd5,
      CSR_ACCEL_2 = 3'd6,
      CSR_ACCEL_3 = 3'd7
   } csr_index_type;

   typedef logic [SPEED_BITS-1:0] speed_type;
   typedef logic [ACCEL_BITS-1:0] accel_type;

   localparam speed_type SPEED_RESET [NUM_PROFILES] = '{
      SPEED_BITS'(12000), SPEED_BITS'(12000), SPEED_BITS'(12000), SPEED_BITS'(12000)
   };
   localparam accel_type ACCEL_RESET [NUM_PROFILES] = '{
      ACCEL_BITS'(95000), ACCEL_BITS'(95000), ACCEL_BITS'(180000), ACCEL_BITS'(17000)
   };

endpackage

`default_nettype wire

FILE: src/three_axis_proportional_rate_split_core.sv
// Top level of the three-axis proportional rate split: pipelined rate scaling.
//
//   Channel   Direction  Handshake             Carries
//   req_      in         req_valid/req_ready   one move command for axes A, B, C
//   rsp_      out        rsp_valid/rsp_ready   scaled speed/accel and start flags
//   csr_      in         csr_valid/csr_ready   profile register index and data
//
// One command is accepted in every cycle unless the result side stalls. A
// command passes stage 1, stage 2 and NUM_DIV_STAGES restoring divider
// stages, which retire DIV_BITS_PER_STAGE quotient bits per stage.
// Reset is synchronous: it clears all valid bits and loads the profile defaults.
// A stall on the result side freezes the whole pipeline, so nothing is lost or
// repeated; req_ready is high whenever the output register is empty or drained.
`default_nettype none

module three_axis_proportional_rate_split_core #(
   parameter int POSITION_BITS = 24,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_opcode,
   input  wire logic [taprs_pkg::PROFILE_BITS-1:0]   req_profile_select,
   input  wire logic signed [POSITION_BITS-1:0]      req_target_a,
   input  wire logic signed [POSITION_BITS-1:0]      req_target_b,
   input  wire logic signed [POSITION_BITS-1:0]      req_target_c,
   input  wire logic signed [POSITION_BITS-1:0]      req_position_a,
   input  wire logic signed [POSITION_BITS-1:0]      req_position_b,
   input  wire logic signed [POSITION_BITS-1:0]      req_position_c,
   input  wire logic                                 req_moving_a,
   input  wire logic                                 req_moving_b,
   input  wire logic                                 req_moving_c,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [taprs_pkg::SPEED_OUT_BITS-1:0]      rsp_speed_a,
   output logic [taprs_pkg::SPEED_OUT_BITS-1:0]      rsp_speed_b,
   output logic [taprs_pkg::SPEED_OUT_BITS-1:0]      rsp_speed_c,
   output logic [taprs_pkg::ACCEL_OUT_BITS-1:0]      rsp_accel_a,
   output logic [taprs_pkg::ACCEL_OUT_BITS-1:0]      rsp_accel_b,
   output logic [taprs_pkg::ACCEL_OUT_BITS-1:0]      rsp_accel_c,
   output logic                                      rsp_start_a,
   output logic                                      rsp_start_b,
   output logic                                      rsp_start_c,

   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [taprs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [taprs_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   import taprs_pkg::*;

   // Distances fit POSITION_BITS unsigned bits: the largest magnitude of a
   // difference of two signed values is 2^POSITION_BITS - 1.
   localparam int DW                 = POSITION_BITS;
   // Speed is widened to the accel width so that all six lanes are alike.
   localparam int RW                 = ACCEL_BITS;
   localparam int PW                 = RW + DW;
   // Since distance never exceeds the largest distance, the quotient is at most
   // rate * 2^FRACTION_BITS and fits QW bits.
   localparam int QW                 = RW + FRACTION_BITS;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int NUM_DIV_STAGES     = (QW + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
   localparam int NUM_AXES           = 3;
   localparam int NUM_LANES          = 2 * NUM_AXES;

   // ---------------------------------------------------------------------
   // Profile registers. The port takes a write in every cycle.
   // ---------------------------------------------------------------------
   speed_type speed_cfg_ff [NUM_PROFILES];
   accel_type accel_cfg_ff [NUM_PROFILES];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_cfg_ff <= SPEED_RESET;
         accel_cfg_ff <= ACCEL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SPEED_0: speed_cfg_ff[0] <= csr_data[SPEED_BITS-1:0];
            CSR_SPEED_1: speed_cfg_ff[1] <= csr_data[SPEED_BITS-1:0];
            CSR_SPEED_2: speed_cfg_ff[2] <= csr_data[SPEED_BITS-1:0];
            CSR_SPEED_3: speed_cfg_ff[3] <= csr_data[SPEED_BITS-1:0];
            CSR_ACCEL_0: accel_cfg_ff[0] <= csr_data[ACCEL_BITS-1:0];
            CSR_ACCEL_1: accel_cfg_ff[1] <= csr_data[ACCEL_BITS-1:0];
            CSR_ACCEL_2: accel_cfg_ff[2] <= csr_data[ACCEL_BITS-1:0];
            CSR_ACCEL_3: accel_cfg_ff[3] <= csr_data[ACCEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Global advance: every stage moves when the output register is free.
   // ---------------------------------------------------------------------
   logic advance;
   logic valid_ff [NUM_DIV_STAGES+1];

   assign advance   = !valid_ff[NUM_DIV_STAGES] || rsp_ready;
   assign req_ready = advance;

   // ---------------------------------------------------------------------
   // Stage 1: per-axis distance and profile lookup.
   // ---------------------------------------------------------------------
   logic signed [DW-1:0] target   [NUM_AXES];
   logic signed [DW-1:0] position [NUM_AXES];
   logic [DW-1:0]        dist_in  [NUM_AXES];

   logic                 s1_valid_ff;
   logic                 s1_push_ff;
   logic [NUM_AXES-1:0]  s1_moving_ff;
   logic [DW-1:0]        s1_dist_ff [NUM_AXES];
   speed_type            s1_speed_ff;
   accel_type            s1_accel_ff;

   assign target[0]   = req_target_a;
   assign target[1]   = req_target_b;
   assign target[2]   = req_target_c;
   assign position[0] = req_position_a;
   assign position[1] = req_position_b;
   assign position[2] = req_position_c;

   // The difference is taken one bit wider so that it never wraps.
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         logic signed [DW:0] diff;
         diff = {target[i][DW-1], target[i]} - {position[i][DW-1], position[i]};
         dist_in[i] = diff[DW] ? DW'(-diff) : diff[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_push_ff   <= (req_opcode == OP_PUSH);
         s1_moving_ff <= {req_moving_c, req_moving_b, req_moving_a};
         s1_dist_ff   <= dist_in;
         s1_speed_ff  <= speed_cfg_ff[req_profile_select];
         s1_accel_ff  <= accel_cfg_ff[req_profile_select];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: largest distance, start decision and rate times distance.
   // The product is split into the initial partial remainder (its upper
   // bits, already below the divisor) and the bits still to shift in.
   // ---------------------------------------------------------------------
   logic [DW-1:0]       dmax_in;
   logic [NUM_AXES-1:0] go_in;
   logic [DW-1:0]       rem_in [NUM_DIV_STAGES+1][NUM_LANES];
   logic [QW-1:0]       qn_in  [NUM_DIV_STAGES+1][NUM_LANES];

   logic [DW-1:0]       rem_ff  [NUM_DIV_STAGES+1][NUM_LANES];
   logic [QW-1:0]       qn_ff   [NUM_DIV_STAGES+1][NUM_LANES];
   logic [DW-1:0]       dmax_ff [NUM_DIV_STAGES+1];
   logic [NUM_AXES-1:0] go_ff   [NUM_DIV_STAGES+1];

   always_comb begin
      logic [DW-1:0] m01;
      m01     = (s1_dist_ff[1] > s1_dist_ff[0]) ? s1_dist_ff[1] : s1_dist_ff[0];
      dmax_in = (s1_dist_ff[2] > m01) ? s1_dist_ff[2] : m01;
   end

   // Nothing starts when there is nothing to move. In push mode an axis
   // starts only when it is stopped and still has distance to go.
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         go_in[i] = (dmax_in != '0) &&
                    (!s1_push_ff || ((s1_dist_ff[i] != '0) && !s1_moving_ff[i]));
      end
   end

   always_comb begin
      for (int j = 0; j < NUM_LANES; j++) begin
         logic [PW-1:0] rate;
         logic [PW-1:0] prod;
         rate = (j < NUM_AXES) ? PW'(s1_speed_ff) : PW'(s1_accel_ff);
         prod = rate * PW'(s1_dist_ff[j % NUM_AXES]);
         rem_in[0][j] = prod[PW-1:RW];
         qn_in[0][j]  = QW'(prod[RW-1:0]) << FRACTION_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= rem_in[0];
         qn_ff[0]   <= qn_in[0];
         dmax_ff[0] <= dmax_in;
         go_ff[0]   <= go_in;
      end
   end

   // ---------------------------------------------------------------------
   // Restoring division, DIV_BITS_PER_STAGE quotient bits per stage. The
   // quotient shifts into the low end of qn while the remaining dividend
   // bits leave at its top. The last stage is the output register.
   // ---------------------------------------------------------------------
   for (genvar k = 0; k < NUM_DIV_STAGES; k++) begin : g_div
      localparam int STEPS = ((QW - k * DIV_BITS_PER_STAGE) < DIV_BITS_PER_STAGE) ?
                             (QW - k * DIV_BITS_PER_STAGE) : DIV_BITS_PER_STAGE;

      always_comb begin
         for (int j = 0; j < NUM_LANES; j++) begin
            logic [DW-1:0] r;
            logic [QW-1:0] q;
            logic [DW:0]   trial;
            logic          fits;
            r = rem_ff[k][j];
            q = qn_ff[k][j];
            for (int s = 0; s < STEPS; s++) begin
               trial = {r, q[QW-1]};
               fits  = (trial >= {1'b0, dmax_ff[k]});
               q     = {q[QW-2:0], fits};
               r     = fits ? DW'(trial - {1'b0, dmax_ff[k]}) : trial[DW-1:0];
            end
            rem_in[k+1][j] = r;
            qn_in[k+1][j]  = q;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1]  <= rem_in[k+1];
            qn_ff[k+1]   <= qn_in[k+1];
            dmax_ff[k+1] <= dmax_ff[k];
            go_ff[k+1]   <= go_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result: an axis that does not start reports zero rates.
   // ---------------------------------------------------------------------
   logic [NUM_AXES-1:0] go_out;

   assign go_out      = go_ff[NUM_DIV_STAGES];
   assign rsp_valid   = valid_ff[NUM_DIV_STAGES];
   assign rsp_start_a = go_out[0];
   assign rsp_start_b = go_out[1];
   assign rsp_start_c = go_out[2];

   assign rsp_speed_a = go_out[0] ? SPEED_OUT_BITS'(qn_ff[NUM_DIV_STAGES][0]) : '0;
   assign rsp_speed_b = go_out[1] ? SPEED_OUT_BITS'(qn_ff[NUM_DIV_STAGES][1]) : '0;
   assign rsp_speed_c = go_out[2] ? SPEED_OUT_BITS'(qn_ff[NUM_DIV_STAGES][2]) : '0;
   assign rsp_accel_a = go_out[0] ? ACCEL_OUT_BITS'(qn_ff[NUM_DIV_STAGES][3]) : '0;
   assign rsp_accel_b = go_out[1] ? ACCEL_OUT_BITS'(qn_ff[NUM_DIV_STAGES][4]) : '0;
   assign rsp_accel_c = go_out[2] ? ACCEL_OUT_BITS'(qn_ff[NUM_DIV_STAGES][5]) : '0;

endmodule

`default_nettype wire

FILE: src/taprs_checker.sv
// Port-level checker of the three-axis proportional rate split core and its bind.
`default_nettype none

`include "three_axis_proportional_rate_split_core_macros.svh"

module taprs_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_ready,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic [taprs_pkg::SPEED_OUT_BITS-1:0] rsp_speed_a,
   input wire logic [taprs_pkg::SPEED_OUT_BITS-1:0] rsp_speed_b,
   input wire logic [taprs_pkg::SPEED_OUT_BITS-1:0] rsp_speed_c,
   input wire logic [taprs_pkg::ACCEL_OUT_BITS-1:0] rsp_accel_a,
   input wire logic [taprs_pkg::ACCEL_OUT_BITS-1:0] rsp_accel_b,
   input wire logic [taprs_pkg::ACCEL_OUT_BITS-1:0] rsp_accel_c,
   input wire logic                                 rsp_start_a,
   input wire logic                                 rsp_start_b,
   input wire logic                                 rsp_start_c,
   input wire logic                                 csr_ready
);

   import taprs_pkg::*;

   // A stalled result keeps its valid, its start flags, speed A and accel C.
   `TAPRS_ASSERT_NEXT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready), (rsp_valid && $stable(rsp_speed_a) && $stable(rsp_accel_c) && $stable({rsp_start_a, rsp_start_b, rsp_start_c})), "stalled transfer changed")

   // An axis that does not start carries zero rates.
   `TAPRS_ASSERT_SAME(a_idle_axis_zero, clock, reset, (rsp_valid && !(rsp_start_a && rsp_start_b && rsp_start_c)), ((rsp_start_a || (rsp_speed_a == '0 && rsp_accel_a == '0)) && (rsp_start_b || (rsp_speed_b == '0 && rsp_accel_b == '0)) && (rsp_start_c || (rsp_speed_c == '0 && rsp_accel_c == '0))), "rates on an axis that does not start")

   // With the output register empty the pipeline must take a command.
   `TAPRS_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "input blocked with empty output")

   // The profile registers take a write at any time.
   `TAPRS_ASSERT_SAME(a_csr_always_ready, clock, reset, 1'b1, csr_ready, "configuration port not ready")

endmodule

bind three_axis_proportional_rate_split_core taprs_checker u_taprs_checker (.*);

`default_nettype wire
